// ===== design/ps2mpt_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2mpt_pkg
// Shared types and constants for the PS/2 mouse packet tracker.
// ----------------------------------------------------------------------------
package ps2mpt_pkg;

    localparam int BYTE_W  = 8;
    localparam int MOVE_W  = 9;
    localparam int LIMIT_W = 12;

    localparam int COORD_WIDTH_DEF = 12;

    localparam logic [LIMIT_W-1:0] LIMIT_X_RST = 12'd1024;
    localparam logic [LIMIT_W-1:0] LIMIT_Y_RST = 12'd768;

    // first-byte flag positions
    localparam int BIT_OVF_Y  = 7;
    localparam int BIT_OVF_X  = 6;
    localparam int BIT_SIGN_Y = 5;
    localparam int BIT_SIGN_X = 4;

    // configuration register indexes
    localparam logic CFG_LIMIT_X = 1'b0;
    localparam logic CFG_LIMIT_Y = 1'b1;

    typedef enum logic [1:0] {
        POS_FIRST = 2'd0,
        POS_X     = 2'd1,
        POS_Y     = 2'd2
    } t_byte_pos;

    typedef struct packed {
        logic                     valid;
        logic signed [MOVE_W-1:0] move_x;
        logic signed [MOVE_W-1:0] move_y;
    } t_pkt;

endpackage

// ===== design/ps2_mouse_packet_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker_unit
// PS/2 mouse packet tracker: three-byte packets in, clamped cursor out.
// ----------------------------------------------------------------------------
// Usage:
//   rx channel (i_rx_valid / o_rx_ready / i_rx_byte) takes one mouse byte per
//   beat. A header byte with either overflow bit set is dropped and the
//   tracker keeps waiting for a header.
//   out channel (o_out_valid / i_out_ready) gives one beat per complete
//   packet: cursor position after the move, plus the packet's X and Y moves.
//   Config port (i_cfg_we / i_cfg_index / i_cfg_data) writes the X and Y
//   clamp limits; write only while the tracker is idle. Throughput: one
//   byte per clock while o_rx_ready is high. Latency: the result beat is
//   valid the cycle after the third byte is taken; the single result
//   register sets it. Header and X bytes are taken even while a result
//   waits; a third byte waits only when the result register is full and
//   the receiver stalls. Reset: limits go to 1024 x 768, tracked cursor
//   position to 0,0, tracker waits for a header byte, no result pending.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker_unit #(
    parameter int COORD_WIDTH = ps2mpt_pkg::COORD_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_rx_valid,
    output logic                                  o_rx_ready,
    input  logic [ps2mpt_pkg::BYTE_W-1:0]         i_rx_byte,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic [ps2mpt_pkg::LIMIT_W-1:0]        o_cursor_x,
    output logic [ps2mpt_pkg::LIMIT_W-1:0]        o_cursor_y,
    output logic signed [ps2mpt_pkg::MOVE_W-1:0]  o_move_x,
    output logic signed [ps2mpt_pkg::MOVE_W-1:0]  o_move_y,
    input  logic                                  i_cfg_we,
    input  logic                                  i_cfg_index,
    input  logic [ps2mpt_pkg::LIMIT_W-1:0]        i_cfg_data
);

    logic [ps2mpt_pkg::LIMIT_W-1:0] r_limit_x, r_limit_y;

    logic            beat;
    logic            last;
    logic            free;
    ps2mpt_pkg::t_pkt pkt;

    assign o_rx_ready = !last || free;
    assign beat       = i_rx_valid && o_rx_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit_x <= ps2mpt_pkg::LIMIT_X_RST;
            r_limit_y <= ps2mpt_pkg::LIMIT_Y_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ps2mpt_pkg::CFG_LIMIT_X: r_limit_x <= i_cfg_data;
                ps2mpt_pkg::CFG_LIMIT_Y: r_limit_y <= i_cfg_data;
                default:                 r_limit_x <= r_limit_x;
            endcase
        end
    end

    ps2mpt_pkt_asm u_pkt_asm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_beat    (beat),
        .i_rx_byte (i_rx_byte),
        .o_last    (last),
        .o_pkt     (pkt)
    );

    ps2mpt_cursor #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_cursor (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pkt       (pkt),
        .i_limit_x   (r_limit_x),
        .i_limit_y   (r_limit_y),
        .i_out_ready (i_out_ready),
        .o_free      (free),
        .o_out_valid (o_out_valid),
        .o_cursor_x  (o_cursor_x),
        .o_cursor_y  (o_cursor_y),
        .o_move_x    (o_move_x),
        .o_move_y    (o_move_y)
    );

endmodule

// ===== design/ps2mpt_pkt_asm.sv =====
// ----------------------------------------------------------------------------
// ps2mpt_pkt_asm
// Byte position tracking and packet assembly: drops overflowed header bytes,
// holds the sign bits and the X move, emits a packet on the third byte.
// ----------------------------------------------------------------------------
module ps2mpt_pkt_asm (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_beat,
    input  logic [ps2mpt_pkg::BYTE_W-1:0]  i_rx_byte,
    output logic                           o_last,
    output ps2mpt_pkg::t_pkt               o_pkt
);

    ps2mpt_pkg::t_byte_pos r_pos, n_pos;

    logic                                r_sign_x, r_sign_y;
    logic signed [ps2mpt_pkg::MOVE_W-1:0] r_held_x;

    logic hdr_ok;

    assign hdr_ok = !(i_rx_byte[ps2mpt_pkg::BIT_OVF_Y] | i_rx_byte[ps2mpt_pkg::BIT_OVF_X]);

    // next state
    always_comb begin
        n_pos = r_pos;
        case (r_pos)
            ps2mpt_pkg::POS_FIRST: begin
                if (i_beat && hdr_ok) begin
                    n_pos = ps2mpt_pkg::POS_X;
                end
            end
            ps2mpt_pkg::POS_X: begin
                if (i_beat) begin
                    n_pos = ps2mpt_pkg::POS_Y;
                end
            end
            default: begin
                // third byte, and the unused code acts the same
                if (i_beat) begin
                    n_pos = ps2mpt_pkg::POS_FIRST;
                end
            end
        endcase
    end

    // outputs
    always_comb begin
        o_last = 1'b0;
        case (r_pos)
            ps2mpt_pkg::POS_FIRST: o_last = 1'b0;
            ps2mpt_pkg::POS_X:     o_last = 1'b0;
            default:               o_last = 1'b1;
        endcase
        o_pkt.valid  = i_beat && o_last;
        o_pkt.move_x = r_held_x;
        o_pkt.move_y = {r_sign_y, i_rx_byte};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= ps2mpt_pkg::POS_FIRST;
            r_sign_x <= 1'b1;
            r_sign_y <= 1'b1;
            r_held_x <= '0;
        end else begin
            r_pos <= n_pos;
            if (i_beat && (r_pos == ps2mpt_pkg::POS_FIRST) && hdr_ok) begin
                r_sign_x <= i_rx_byte[ps2mpt_pkg::BIT_SIGN_X];
                r_sign_y <= i_rx_byte[ps2mpt_pkg::BIT_SIGN_Y];
            end
            if (i_beat && (r_pos == ps2mpt_pkg::POS_X)) begin
                r_held_x <= {r_sign_x, i_rx_byte};
            end
        end
    end

endmodule

// ===== design/ps2mpt_cursor.sv =====
// ----------------------------------------------------------------------------
// ps2mpt_cursor
// Cursor position update with clamping, and the result register.
// ----------------------------------------------------------------------------
module ps2mpt_cursor #(
    parameter int COORD_WIDTH = ps2mpt_pkg::COORD_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  ps2mpt_pkg::t_pkt                      i_pkt,
    input  logic [ps2mpt_pkg::LIMIT_W-1:0]        i_limit_x,
    input  logic [ps2mpt_pkg::LIMIT_W-1:0]        i_limit_y,
    input  logic                                  i_out_ready,
    output logic                                  o_free,
    output logic                                  o_out_valid,
    output logic [ps2mpt_pkg::LIMIT_W-1:0]        o_cursor_x,
    output logic [ps2mpt_pkg::LIMIT_W-1:0]        o_cursor_y,
    output logic signed [ps2mpt_pkg::MOVE_W-1:0]  o_move_x,
    output logic signed [ps2mpt_pkg::MOVE_W-1:0]  o_move_y
);

    localparam int LW = ps2mpt_pkg::LIMIT_W;
    localparam int MW = ps2mpt_pkg::MOVE_W;
    // room for the larger of coordinate and limit, plus carry and sign
    localparam int CW = ((COORD_WIDTH > LW) ? COORD_WIDTH : LW) + 2;
    localparam logic [CW-1:0] COORD_MAX = CW'((64'd1 << COORD_WIDTH) - 64'd1);

    logic [COORD_WIDTH-1:0] r_pos_x, r_pos_y;

    logic                 r_out_valid;
    logic [LW-1:0]        r_cursor_x, r_cursor_y;
    logic signed [MW-1:0] r_move_x, r_move_y;

    logic [CW-1:0] lim_x, lim_y, eff_x, eff_y;
    logic [CW-1:0] sum_x, sum_y, clp_x, clp_y;

    assign lim_x = {{(CW-LW){1'b0}}, i_limit_x};
    assign lim_y = {{(CW-LW){1'b0}}, i_limit_y};
    assign eff_x = (lim_x > COORD_MAX) ? COORD_MAX : lim_x;
    assign eff_y = (lim_y > COORD_MAX) ? COORD_MAX : lim_y;

    // screen y grows downward, so the y move is subtracted
    assign sum_x = {{(CW-COORD_WIDTH){1'b0}}, r_pos_x}
                 + {{(CW-MW){i_pkt.move_x[MW-1]}}, i_pkt.move_x};
    assign sum_y = {{(CW-COORD_WIDTH){1'b0}}, r_pos_y}
                 - {{(CW-MW){i_pkt.move_y[MW-1]}}, i_pkt.move_y};

    always_comb begin
        if (sum_x[CW-1]) begin
            clp_x = '0;
        end else if (sum_x > eff_x) begin
            clp_x = eff_x;
        end else begin
            clp_x = sum_x;
        end
        if (sum_y[CW-1]) begin
            clp_y = '0;
        end else if (sum_y > eff_y) begin
            clp_y = eff_y;
        end else begin
            clp_y = sum_y;
        end
    end

    assign o_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pos_x     <= '0;
            r_pos_y     <= '0;
        end else begin
            if (i_pkt.valid) begin
                r_out_valid <= 1'b1;
                r_pos_x     <= clp_x[COORD_WIDTH-1:0];
                r_pos_y     <= clp_y[COORD_WIDTH-1:0];
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pkt.valid) begin
            r_cursor_x <= clp_x[LW-1:0];
            r_cursor_y <= clp_y[LW-1:0];
            r_move_x   <= i_pkt.move_x;
            r_move_y   <= i_pkt.move_y;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cursor_x  = r_cursor_x;
    assign o_cursor_y  = r_cursor_y;
    assign o_move_x    = r_move_x;
    assign o_move_y    = r_move_y;

endmodule

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PS/2 mouse packet tracker. A queue-fed driver
// pushes mouse bytes over the rx channel and a shadow tracker predicts every
// cursor report. A monitor checks each report beat against the oldest
// prediction. Clamp limits change between phases, and the phases vary the
// mix of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct packed {
        logic [ps2mpt_pkg::LIMIT_W-1:0]        cursor_x;
        logic [ps2mpt_pkg::LIMIT_W-1:0]        cursor_y;
        logic signed [ps2mpt_pkg::MOVE_W-1:0]  move_x;
        logic signed [ps2mpt_pkg::MOVE_W-1:0]  move_y;
    } t_cursor_report;

    logic                                  i_clk       = 1'b0;
    logic                                  i_rst_n     = 1'b0;
    logic                                  i_rx_valid  = 1'b0;
    logic [ps2mpt_pkg::BYTE_W-1:0]         i_rx_byte   = '0;
    logic                                  i_out_ready = 1'b0;
    logic                                  i_cfg_we    = 1'b0;
    logic                                  i_cfg_index = ps2mpt_pkg::CFG_LIMIT_X;
    logic [ps2mpt_pkg::LIMIT_W-1:0]        i_cfg_data  = '0;
    logic                                  o_rx_ready;
    logic                                  o_out_valid;
    logic [ps2mpt_pkg::LIMIT_W-1:0]        o_cursor_x;
    logic [ps2mpt_pkg::LIMIT_W-1:0]        o_cursor_y;
    logic signed [ps2mpt_pkg::MOVE_W-1:0]  o_move_x;
    logic signed [ps2mpt_pkg::MOVE_W-1:0]  o_move_y;

    logic [ps2mpt_pkg::BYTE_W-1:0] mouse_bytes[$];
    t_cursor_report                pending_reports[$];
    int                            sender_idle_pct = 0;
    int                            recv_stall_pct  = 0;
    int                            error_count     = 0;
    int                            cycle_count     = 0;

    // shadow copy of the tracker
    ps2mpt_pkg::t_byte_pos                 trk_pos    = ps2mpt_pkg::POS_FIRST;
    logic                                  trk_sign_x = 1'b1;
    logic                                  trk_sign_y = 1'b1;
    logic signed [ps2mpt_pkg::MOVE_W-1:0]  trk_held_x = '0;
    logic [ps2mpt_pkg::LIMIT_W-1:0]        trk_cur_x  = '0;
    logic [ps2mpt_pkg::LIMIT_W-1:0]        trk_cur_y  = '0;
    logic [ps2mpt_pkg::LIMIT_W-1:0]        trk_lim_x  = ps2mpt_pkg::LIMIT_X_RST;
    logic [ps2mpt_pkg::LIMIT_W-1:0]        trk_lim_y  = ps2mpt_pkg::LIMIT_Y_RST;

    ps2_mouse_packet_tracker_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_valid  (i_rx_valid),
        .o_rx_ready  (o_rx_ready),
        .i_rx_byte   (i_rx_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cursor_x  (o_cursor_x),
        .o_cursor_y  (o_cursor_y),
        .o_move_x    (o_move_x),
        .o_move_y    (o_move_y),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic logic [ps2mpt_pkg::LIMIT_W-1:0] clip_to_screen(
        int v, logic [ps2mpt_pkg::LIMIT_W-1:0] lim);
        if (v > int'(lim))
            return lim;
        if (v < 0)
            return '0;
        return v[ps2mpt_pkg::LIMIT_W-1:0];
    endfunction

    task automatic track_mouse_byte(input logic [ps2mpt_pkg::BYTE_W-1:0] b);
        t_cursor_report                       rep;
        logic signed [ps2mpt_pkg::MOVE_W-1:0] dy;
        int                                   nx;
        int                                   ny;
        case (trk_pos)
            ps2mpt_pkg::POS_FIRST: begin
                // header with an overflow flag is dropped outright
                if (!(b[ps2mpt_pkg::BIT_OVF_Y] || b[ps2mpt_pkg::BIT_OVF_X])) begin
                    trk_sign_x = b[ps2mpt_pkg::BIT_SIGN_X];
                    trk_sign_y = b[ps2mpt_pkg::BIT_SIGN_Y];
                    trk_pos    = ps2mpt_pkg::POS_X;
                end
            end
            ps2mpt_pkg::POS_X: begin
                trk_held_x = {trk_sign_x, b};
                trk_pos    = ps2mpt_pkg::POS_Y;
            end
            default: begin
                dy        = {trk_sign_y, b};
                nx        = int'(trk_cur_x) + int'(trk_held_x);
                ny        = int'(trk_cur_y) - int'(dy);   // screen y grows downward
                trk_cur_x = clip_to_screen(nx, trk_lim_x);
                trk_cur_y = clip_to_screen(ny, trk_lim_y);
                rep.cursor_x = trk_cur_x;
                rep.cursor_y = trk_cur_y;
                rep.move_x   = trk_held_x;
                rep.move_y   = dy;
                pending_reports.push_back(rep);
                trk_pos = ps2mpt_pkg::POS_FIRST;
            end
        endcase
    endtask

    // rx driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_rx_valid <= 1'b0;
        end else begin
            if (i_rx_valid && o_rx_ready)
                track_mouse_byte(i_rx_byte);
            if (!i_rx_valid || o_rx_ready) begin
                if (mouse_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    i_rx_valid <= 1'b1;
                    i_rx_byte  <= mouse_bytes.pop_front();
                end else begin
                    i_rx_valid <= 1'b0;
                end
            end
        end
    end

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // report monitor
    always @(posedge i_clk) begin : report_monitor
        t_cursor_report want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_reports.size() == 0) begin
                    $error("report beat with none pending: x=%0d y=%0d", o_cursor_x, o_cursor_y);
                    error_count++;
                end else begin
                    want = pending_reports.pop_front();
                    check_field("cursor_x", int'(want.cursor_x), int'(o_cursor_x));
                    check_field("cursor_y", int'(want.cursor_y), int'(o_cursor_y));
                    check_field("move_x", int'(want.move_x), int'(o_move_x));
                    check_field("move_y", int'(want.move_y), int'(o_move_y));
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic wait_quiet();
        while (mouse_bytes.size() != 0 || i_rx_valid || pending_reports.size() != 0)
            @(negedge i_clk);
        // header and X bytes leave no report, give them time to land
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic idx, input logic [ps2mpt_pkg::LIMIT_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx == ps2mpt_pkg::CFG_LIMIT_X)
            trk_lim_x = val;
        else
            trk_lim_y = val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic push_packet(input logic [ps2mpt_pkg::BYTE_W-1:0] hdr, dx, dy);
        mouse_bytes.push_back(hdr);
        mouse_bytes.push_back(dx);
        mouse_bytes.push_back(dy);
    endtask

    task automatic queue_random(input int count);
        int                            pushed;
        int                            pick;
        logic [ps2mpt_pkg::BYTE_W-1:0] hdr;
        pushed = 0;
        while (pushed < count) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                // stray byte, knocks the packet framing off
                mouse_bytes.push_back(ps2mpt_pkg::BYTE_W'($urandom_range(255)));
                pushed++;
            end else if (pick < 14) begin
                hdr = ps2mpt_pkg::BYTE_W'($urandom_range(255));
                if (!(hdr[ps2mpt_pkg::BIT_OVF_Y] || hdr[ps2mpt_pkg::BIT_OVF_X]))
                    hdr[$urandom_range(1) ? ps2mpt_pkg::BIT_OVF_Y : ps2mpt_pkg::BIT_OVF_X] = 1'b1;
                mouse_bytes.push_back(hdr);
                pushed++;
            end else begin
                hdr = ps2mpt_pkg::BYTE_W'($urandom_range(255));
                hdr[ps2mpt_pkg::BIT_OVF_Y] = 1'b0;
                hdr[ps2mpt_pkg::BIT_OVF_X] = 1'b0;
                push_packet(hdr, ps2mpt_pkg::BYTE_W'($urandom_range(255)),
                            ps2mpt_pkg::BYTE_W'($urandom_range(255)));
                pushed += 3;
            end
        end
    endtask

    // half the phase, a full drain, then the rest
    task automatic run_phase(input int count);
        queue_random(count / 2);
        wait_quiet();
        queue_random(count - count / 2);
        wait_quiet();
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // overflow headers, ignored low header bits, move extremes
        mouse_bytes.push_back(8'hC0);
        mouse_bytes.push_back(8'h80);
        mouse_bytes.push_back(8'h40);
        push_packet(8'h0F, 8'hFF, 8'hFF);
        push_packet(8'h30, 8'h00, 8'h00);
        push_packet(8'h10, 8'hFF, 8'h7F);
        push_packet(8'h20, 8'h80, 8'h80);
        push_packet(8'h00, 8'hFF, 8'h00);
        mouse_bytes.push_back(8'hF0);
        push_packet(8'h00, 8'h00, 8'h00);
        wait_quiet();
        run_phase(180);

        write_limit(ps2mpt_pkg::CFG_LIMIT_X, 12'd4095);
        write_limit(ps2mpt_pkg::CFG_LIMIT_Y, 12'd4095);
        sender_idle_pct = 66;
        run_phase(250);

        // limits dropped below the current cursor
        write_limit(ps2mpt_pkg::CFG_LIMIT_X, 12'd0);
        write_limit(ps2mpt_pkg::CFG_LIMIT_Y, 12'd0);
        sender_idle_pct = 0;
        recv_stall_pct  = 66;
        run_phase(200);

        write_limit(ps2mpt_pkg::CFG_LIMIT_X, 12'd100);
        write_limit(ps2mpt_pkg::CFG_LIMIT_Y, 12'd37);
        sender_idle_pct = 31;
        recv_stall_pct  = 31;
        run_phase(250);

        write_limit(ps2mpt_pkg::CFG_LIMIT_X, 12'd4095);
        write_limit(ps2mpt_pkg::CFG_LIMIT_Y, 12'd1);
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        run_phase(200);

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
